FILE: rtl/scg_pkg.sv
`default_nettype none

package scg_pkg;

    // Geometry defaults
    localparam int DEF_COLUMNS = 64;
    localparam int DEF_ROWS    = 32;

    // Font store: eight bytes per glyph, codes FIRST_CODE..LAST_CODE
    localparam int FONT_BYTES = 728;
    localparam int FONT_AW    = 10;
    localparam int FIRST_CODE = 32;
    localparam int LAST_CODE  = 122;

    localparam int COLOR_W = 16;
    localparam int CFG_IW  = 1;

    // Input item field widths
    localparam int FUNC_W   = 2;
    localparam int COLUMN_W = 6;
    localparam int CODE_W   = 8;
    localparam int PX_W     = 9;
    localparam int PY_W     = 8;
    localparam int FIDX_W   = 10;
    localparam int FBITS_W  = 8;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    // Row length register width (holds 0..64)
    localparam int LEN_REG_W = 7;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE_CHAR = 2'd0,
        FUNC_NEW_LINE   = 2'd1,
        FUNC_READ_PIXEL = 2'd2,
        FUNC_LOAD_FONT  = 2'd3
    } func_t;

    typedef enum logic [CFG_IW-1:0] {
        REG_INK   = 1'b0,
        REG_PAPER = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEXT,
        ST_FONT
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/scrolling_text_char_generator.sv
`default_nettype none

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser=func, tdata=operands
// m_axis    out  m_axis_tvalid/m_axis_tready    tuser=is_pixel, tdata=pixel_color
// cfg       in   cfg_we (no wait)               cfg_index, cfg_wdata
//
// Char writes, new lines and font loads: the item is accepted and its result
// is loaded into the output register at the same edge.
// A pixel read runs a text memory read, then a font memory read, then the color
// goes to the output register once that is free. One item is in work at a time.
// Reset clears the row lengths (flops) and the scroll pointer and sets ink to
// all ones, paper to zero; the text and font memories are not cleared, so there
// is no clearing pass. An item is accepted only while the output register is
// empty or its result is taken at the same edge; a stalled output holds off items.

module scrolling_text_char_generator
    import scg_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input items
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [5:0] column, [13:6] char_code, [22:14] pixel_x, [30:23] pixel_y,
    // [40:31] font_index, [48:41] font_bits, [55:49] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] func
    input  wire logic [FUNC_W-1:0]     s_axis_tuser,
    // result items
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [15:0] pixel_color
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // [0] is_pixel
    output logic [0:0]                 m_axis_tuser,
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IW-1:0]     cfg_index,
    input  wire logic [COLOR_W-1:0]    cfg_wdata
);

    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LEN_W  = $clog2(COLUMNS + 1);
    localparam int TEXT_DEPTH = ROWS * COLUMNS;
    localparam int TA_W   = $clog2(TEXT_DEPTH);
    localparam int BANDS  = 32;

    // ---------------- input field unpacking ----------------
    func_t                 func;
    logic [COLUMN_W-1:0]   column;
    logic [CODE_W-1:0]     char_code;
    logic [PX_W-1:0]       pixel_x;
    logic [PY_W-1:0]       pixel_y;
    logic [FIDX_W-1:0]     font_index;
    logic [FBITS_W-1:0]    font_bits;

    assign func       = func_t'(s_axis_tuser);
    assign column     = s_axis_tdata[5:0];
    assign char_code  = s_axis_tdata[13:6];
    assign pixel_x    = s_axis_tdata[22:14];
    assign pixel_y    = s_axis_tdata[30:23];
    assign font_index = s_axis_tdata[40:31];
    assign font_bits  = s_axis_tdata[48:41];

    // ---------------- registers ----------------
    state_t                state_reg, state_next;
    logic [COLOR_W-1:0]    ink_reg, paper_reg;
    logic [ROW_W-1:0]      scroll_reg, scroll_next;
    logic [LEN_W-1:0]      row_len_reg [ROWS];

    logic                  out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]    out_color_reg, out_color_next;
    logic                  out_pix_reg, out_pix_next;

    // pixel read context carried through the memory reads
    logic                  blank_reg, blank_next;
    logic [2:0]            sub_reg, sub_next;
    logic [2:0]            line_reg, line_next;

    // memories
    logic [CODE_W-1:0]     text_mem [TEXT_DEPTH];
    logic [FBITS_W-1:0]    font_mem [FONT_BYTES];
    logic [CODE_W-1:0]     text_rdata_reg;
    logic [FBITS_W-1:0]    font_rdata_reg;

    logic                  text_we, text_re, font_we, font_re, len_we;
    logic [TA_W-1:0]       text_waddr, text_raddr;
    logic [FONT_AW-1:0]    font_raddr;
    logic [LEN_W-1:0]      len_wdata;

    logic                  in_accept;
    logic                  out_free;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_color_reg;
    assign m_axis_tuser[0] = out_pix_reg;

    // ---------------- pixel address path ----------------
    // frame row band mod ROWS, as a constant table
    logic [ROW_W-1:0]      band_mod [BANDS];
    for (genvar g = 0; g < BANDS; g++) begin : g_band
        assign band_mod[g] = ROW_W'(g % ROWS);
    end

    logic [ROW_W-1:0]      top_row;    // scroll + 1 mod ROWS
    logic [ROW_W:0]        row_sum;
    logic [ROW_W-1:0]      pix_row;
    logic [LEN_REG_W-1:0]  pix_col;
    logic [LEN_REG_W-1:0]  pix_len;
    logic                  pix_blank;

    assign top_row  = (scroll_reg == ROW_W'(ROWS - 1)) ? '0 : scroll_reg + 1'b1;
    assign row_sum  = {1'b0, band_mod[pixel_y[7:3]]} + {1'b0, top_row};
    assign pix_row  = (row_sum >= (ROW_W + 1)'(ROWS)) ?
                      ROW_W'(row_sum - (ROW_W + 1)'(ROWS)) : ROW_W'(row_sum);
    assign pix_col  = {1'b0, pixel_x[8:3]};
    assign pix_len  = LEN_REG_W'(row_len_reg[pix_row]);
    assign pix_blank = (pix_col >= pix_len) || (pix_col >= LEN_REG_W'(COLUMNS));

    assign text_raddr = TA_W'(TA_W'(pix_row) * TA_W'(COLUMNS) + TA_W'(pix_col));
    assign text_waddr = TA_W'(TA_W'(scroll_reg) * TA_W'(COLUMNS) + TA_W'(column));

    // glyph code check and font address after the text read
    logic                  code_bad;
    logic [CODE_W-1:0]     glyph;
    logic                  font_bit;

    assign code_bad   = (text_rdata_reg < CODE_W'(FIRST_CODE)) ||
                        (text_rdata_reg > CODE_W'(LAST_CODE));
    assign glyph      = text_rdata_reg - CODE_W'(FIRST_CODE);
    assign font_raddr = {glyph[6:0], line_reg};
    assign font_bit   = font_rdata_reg[3'd7 - sub_reg];

    // terminator length, clipped to the row width
    assign len_wdata = ({1'b0, column} < LEN_REG_W'(COLUMNS)) ?
                       LEN_W'(column) : LEN_W'(COLUMNS);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        scroll_next    = scroll_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_color_next = out_color_reg;
        out_pix_next   = out_pix_reg;
        blank_next     = blank_reg;
        sub_next       = sub_reg;
        line_next      = line_reg;
        text_we        = 1'b0;
        text_re        = 1'b0;
        font_we        = 1'b0;
        font_re        = 1'b0;
        len_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (func == FUNC_READ_PIXEL)
                    begin
                        text_re    = 1'b1;
                        blank_next = pix_blank;
                        sub_next   = pixel_x[2:0];
                        line_next  = 3'd7 - pixel_y[2:0];
                        state_next = ST_TEXT;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_color_next = '0;
                        out_pix_next   = 1'b0;
                        case (func)
                            FUNC_WRITE_CHAR:
                            begin
                                if (char_code == '0)
                                    len_we = 1'b1;
                                else if ({1'b0, column} < LEN_REG_W'(COLUMNS))
                                    text_we = 1'b1;
                            end
                            FUNC_NEW_LINE:
                            begin
                                scroll_next = (scroll_reg == '0) ?
                                              ROW_W'(ROWS - 1) : scroll_reg - 1'b1;
                            end
                            default:
                            begin
                                font_we = (font_index < FIDX_W'(FONT_BYTES));
                            end
                        endcase
                    end
                end
            end
            ST_TEXT:
            begin
                font_re    = 1'b1;
                blank_next = blank_reg || code_bad;
                state_next = ST_FONT;
            end
            ST_FONT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_color_next = (!blank_reg && font_bit) ? ink_reg : paper_reg;
                    out_pix_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scroll_reg    <= '0;
            out_valid_reg <= 1'b0;
            ink_reg       <= '1;
            paper_reg     <= '0;
            for (int r = 0; r < ROWS; r++)
            begin
                row_len_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            scroll_reg    <= scroll_next;
            out_valid_reg <= out_valid_next;
            if (len_we)
                row_len_reg[scroll_reg] <= len_wdata;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_INK:   ink_reg   <= cfg_wdata;
                    REG_PAPER: paper_reg <= cfg_wdata;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_color_reg <= out_color_next;
        out_pix_reg   <= out_pix_next;
        blank_reg     <= blank_next;
        sub_reg       <= sub_next;
        line_reg      <= line_next;
    end

    // text memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (text_we)
            text_mem[text_waddr] <= char_code;
        if (text_re)
            text_rdata_reg <= text_mem[text_raddr];
    end

    // font memory
    always_ff @(posedge clk)
    begin
        if (font_we)
            font_mem[font_index] <= font_bits;
        if (font_re)
            font_rdata_reg <= font_mem[font_raddr];
    end

    // ---------------- assertions ----------------
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("item accepted while a pixel read is in work");

    a_pixel_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && func == FUNC_READ_PIXEL) |=>
        (state_reg == ST_TEXT) ##1 (state_reg == ST_FONT))
        else $error("pixel read did not walk text then font read");

    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && func != FUNC_READ_PIXEL) |=>
        (out_valid_reg && !out_pix_reg && out_color_reg == '0))
        else $error("non-pixel item gave no zero result");

    a_scroll_range: assert property (@(posedge clk) disable iff (!rst_n)
        scroll_reg <= ROW_W'(ROWS - 1))
        else $error("scroll pointer out of ring");

endmodule

`default_nettype wire

FILE: tb/scrolling_text_char_generator_test.sv
`default_nettype none

// Self-checking bench for the scrolling text console.
//
// The bench keeps its own copy of the console: text rows, row lengths, scroll
// pointer, font bytes and both colors. Every item accepted on s_axis updates
// that copy and queues the one result item it must produce. The m_axis side
// pops and compares each result item as it is taken.
//
// Flow: reset, a short table of directed items (some with their answers typed
// in), then six phases of random traffic. Each phase starts with both color
// registers rewritten while the block is idle.
//
// The text and font memories come up unknown. The bench tracks which entries
// have been written and never lets a pixel read land on an unwritten one. Such
// a read is swapped for a font load.

module scrolling_text_char_generator_test;
    import scg_pkg::*;

    localparam int COLUMNS = DEF_COLUMNS;
    localparam int ROWS    = DEF_ROWS;

    // one input item, unpacked
    typedef struct {
        func_t               func;
        logic [COLUMN_W-1:0] column;
        logic [CODE_W-1:0]   code;
        logic [PX_W-1:0]     px;
        logic [PY_W-1:0]     py;
        logic [FIDX_W-1:0]   fidx;
        logic [FBITS_W-1:0]  fbits;
    } op_t;

    // one result item
    typedef struct {
        logic [COLOR_W-1:0] color;
        logic               is_pixel;
    } answer_t;

    // directed row: a/b are column/code, pixel_x/pixel_y or index/bits by func
    typedef struct {
        func_t              func;
        int unsigned        a;
        int unsigned        b;
        bit                 known;
        logic [COLOR_W-1:0] color;
    } plan_row_t;

    localparam int PLAN_LEN = 25;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [5:0] column, [13:6] char_code, [22:14] pixel_x, [30:23] pixel_y,
    // [40:31] font_index, [48:41] font_bits, [55:49] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [1:0] func
    logic [FUNC_W-1:0]     s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [15:0] pixel_color
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [0] is_pixel
    logic [0:0]            m_axis_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IW-1:0]     cfg_index = REG_INK;
    logic [COLOR_W-1:0]    cfg_wdata = '0;

    // console copy
    logic [CODE_W-1:0]    text_mem  [ROWS*COLUMNS];
    bit                   text_seen [ROWS*COLUMNS];
    logic [LEN_REG_W-1:0] len_mem   [ROWS];
    int unsigned          scroll_m;
    logic [FBITS_W-1:0]   font_mem  [FONT_BYTES];
    bit                   font_seen [FONT_BYTES];
    logic [COLOR_W-1:0]   ink_m;
    logic [COLOR_W-1:0]   paper_m;

    answer_t     awaited_colors [$];
    int unsigned ready_glyphs [$];   // glyphs with all eight lines loaded
    plan_row_t   plan [PLAN_LEN];
    int unsigned faults = 0;
    int unsigned items_sent = 0;
    bit          calm = 1'b0;        // no idling on either side while set

    scrolling_text_char_generator #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned draw_wait();
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    // every field random; the fields the func ignores stay that way
    function automatic op_t noise_op(func_t f);
        op_t op;
        op.func   = f;
        op.column = COLUMN_W'($urandom);
        op.code   = CODE_W'($urandom);
        op.px     = PX_W'($urandom);
        op.py     = PY_W'($urandom);
        op.fidx   = FIDX_W'($urandom);
        op.fbits  = FBITS_W'($urandom);
        return op;
    endfunction

    function automatic op_t shape(func_t f, int unsigned a, int unsigned b);
        op_t op;
        op = noise_op(f);
        case (f)
            FUNC_WRITE_CHAR:
            begin
                op.column = COLUMN_W'(a);
                op.code   = CODE_W'(b);
            end
            FUNC_READ_PIXEL:
            begin
                op.px = PX_W'(a);
                op.py = PY_W'(b);
            end
            FUNC_LOAD_FONT:
            begin
                op.fidx  = FIDX_W'(a);
                op.fbits = FBITS_W'(b);
            end
            default: ;
        endcase
        return op;
    endfunction

    function automatic plan_row_t step(func_t f, int unsigned a, int unsigned b,
                                       bit known, logic [COLOR_W-1:0] color);
        plan_row_t r;
        r.func  = f;
        r.a     = a;
        r.b     = b;
        r.known = known;
        r.color = color;
        return r;
    endfunction

    // Color of one frame pixel. unwritten flags a read of a text or font
    // entry that was never loaded.
    function automatic logic [COLOR_W-1:0] predict_color(logic [PX_W-1:0] px,
                                                         logic [PY_W-1:0] py,
                                                         output bit unwritten);
        int unsigned row;
        int unsigned col;
        int unsigned code;
        int unsigned addr;
        logic [FBITS_W-1:0] bits;
        unwritten = 1'b0;
        row = (int'(py) / 8 + scroll_m + 1) % ROWS;
        col = int'(px) / 8;
        if (col >= len_mem[row] || col >= COLUMNS)
            return paper_m;
        if (!text_seen[row*COLUMNS + col])
            unwritten = 1'b1;
        code = text_mem[row*COLUMNS + col];
        if (code < FIRST_CODE || code > LAST_CODE)
            return paper_m;
        // glyph lines are stored bottom up
        addr = 8 * (code - FIRST_CODE) + (7 - int'(py) % 8);
        if (!font_seen[addr])
            unwritten = 1'b1;
        bits = font_mem[addr];
        return bits[7 - int'(px) % 8] ? ink_m : paper_m;
    endfunction

    // Update the console copy for one accepted item and queue its answer.
    task automatic console_apply(input op_t op, input bit known,
                                 input logic [COLOR_W-1:0] known_color);
        answer_t ans;
        bit unwritten;
        int unsigned cur;
        cur = scroll_m;
        ans.color    = '0;
        ans.is_pixel = 1'b0;
        case (op.func)
            FUNC_WRITE_CHAR:
            begin
                if (op.code == 0)
                    len_mem[cur] = (int'(op.column) < COLUMNS) ?
                                   LEN_REG_W'(op.column) : LEN_REG_W'(COLUMNS);
                else if (int'(op.column) < COLUMNS)
                begin
                    text_mem[cur*COLUMNS + op.column]  = op.code;
                    text_seen[cur*COLUMNS + op.column] = 1'b1;
                end
            end
            FUNC_NEW_LINE:
                scroll_m = (cur + ROWS - 1) % ROWS;
            FUNC_READ_PIXEL:
            begin
                ans.color    = predict_color(op.px, op.py, unwritten);
                ans.is_pixel = 1'b1;
            end
            default:
            begin
                if (op.fidx < FONT_BYTES)
                begin
                    font_mem[op.fidx]  = op.fbits;
                    font_seen[op.fidx] = 1'b1;
                end
            end
        endcase
        if (known)
        begin
            ans.color    = known_color;
            ans.is_pixel = (op.func == FUNC_READ_PIXEL);
        end
        awaited_colors.push_back(ans);
    endtask

    // Drive one item, wait for the handshake, then record it. Entered and
    // left right after a rising edge; valid stays high for back-to-back items.
    task automatic send(input op_t op, input bit known,
                        input logic [COLOR_W-1:0] color);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op.func;
        s_axis_tdata  <= IN_DATA_W'({op.fbits, op.fidx, op.py, op.px, op.code, op.column});
        do
            @(posedge clk);
        while (!s_axis_tready);
        console_apply(op, known, color);
    endtask

    // random traffic goes through here; unsafe pixel reads become font loads
    task automatic emit(input op_t op);
        bit unwritten;
        logic [COLOR_W-1:0] probe;
        if (op.func == FUNC_READ_PIXEL)
        begin
            probe = predict_color(op.px, op.py, unwritten);
            if (unwritten)
                op = shape(FUNC_LOAD_FONT, $urandom_range(0, FONT_BYTES - 1), $urandom);
        end
        send(op, 1'b0, '0);
        items_sent++;
    endtask

    // stop sending and wait (bounded) for every queued answer
    task automatic drain();
        int n;
        s_axis_tvalid <= 1'b0;
        for (n = 0; n < 5000 && awaited_colors.size() != 0; n++)
            @(posedge clk);
    endtask

    // only called with the block idle
    task automatic write_colors(input logic [COLOR_W-1:0] ink_v,
                                input logic [COLOR_W-1:0] paper_v);
        cfg_we    <= 1'b1;
        cfg_index <= REG_INK;
        cfg_wdata <= ink_v;
        @(posedge clk);
        cfg_index <= REG_PAPER;
        cfg_wdata <= paper_v;
        @(posedge clk);
        cfg_we <= 1'b0;
        ink_m   = ink_v;
        paper_m = paper_v;
    endtask

    // one glyph, all eight lines; now and then a load past the font store
    task automatic font_burst();
        int unsigned g;
        int unsigned l;
        int unsigned bits;
        g = $urandom_range(0, LAST_CODE - FIRST_CODE);
        for (l = 0; l < 8; l++)
        begin
            case ($urandom_range(0, 3))
                0:       bits = 8'h00;
                1:       bits = 8'hFF;
                default: bits = $urandom_range(0, 255);
            endcase
            emit(shape(FUNC_LOAD_FONT, 8*g + l, bits));
        end
        ready_glyphs.push_back(g);
        if ($urandom_range(0, 7) == 0)
            emit(shape(FUNC_LOAD_FONT, $urandom_range(FONT_BYTES, 1023), $urandom));
    endtask

    // a line of text, its terminator, often a new line after it
    task automatic line_burst();
        int unsigned n;
        int unsigned c;
        int unsigned code;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 16);
        for (c = 0; c < n; c++)
        begin
            if (ready_glyphs.size() != 0 && $urandom_range(0, 3) != 0)
                code = FIRST_CODE + ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
            else
                code = $urandom_range(1, 255);
            emit(shape(FUNC_WRITE_CHAR, c, code));
        end
        emit(shape(FUNC_WRITE_CHAR, n, 0));
        if ($urandom_range(0, 1) == 0)
            emit(shape(FUNC_NEW_LINE, 0, 0));
    endtask

    // pixel reads aimed mostly inside rows that hold text
    task automatic pixel_burst();
        int unsigned k;
        int unsigned i;
        int unsigned t;
        int unsigned band;
        int unsigned row;
        int unsigned col;
        int unsigned px;
        int unsigned py;
        bit unwritten;
        logic [COLOR_W-1:0] probe;
        k = $urandom_range(4, 24);
        for (i = 0; i < k; i++)
        begin
            for (t = 0; t < 8; t++)
            begin
                band = $urandom_range(0, 31);
                row  = (band + scroll_m + 1) % ROWS;
                if (len_mem[row] != 0 && $urandom_range(0, 3) != 0)
                    col = $urandom_range(0, len_mem[row] - 1);
                else
                    col = $urandom_range(0, 63);
                px = col * 8 + $urandom_range(0, 7);
                py = band * 8 + $urandom_range(0, 7);
                probe = predict_color(PX_W'(px), PY_W'(py), unwritten);
                if (!unwritten)
                    break;
            end
            emit(shape(FUNC_READ_PIXEL, px, py));
        end
    endtask

    // result side: compare against the oldest answer, stall at random
    initial
    begin
        answer_t ans;
        int unsigned out_hold;
        out_hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_colors.size() == 0)
                begin
                    $error("result item with nothing queued: pixel_color %h", m_axis_tdata);
                    faults++;
                end
                else
                begin
                    ans = awaited_colors.pop_front();
                    if (m_axis_tdata !== ans.color)
                    begin
                        $error("pixel_color expected %h actual %h", ans.color, m_axis_tdata);
                        faults++;
                    end
                    if (m_axis_tuser[0] !== ans.is_pixel)
                    begin
                        $error("is_pixel expected %b actual %b", ans.is_pixel,
                               m_axis_tuser[0]);
                        faults++;
                    end
                end
                out_hold = draw_wait();
            end
            if (out_hold != 0)
            begin
                m_axis_tready <= 1'b0;
                out_hold--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        logic [COLOR_W-1:0] inks   [6];
        logic [COLOR_W-1:0] papers [6];
        int i;
        int unsigned target;
        int unsigned pick;

        // reset state of the copy; memories start unwritten
        for (i = 0; i < ROWS*COLUMNS; i++)
        begin
            text_mem[i]  = '0;
            text_seen[i] = 1'b0;
        end
        for (i = 0; i < FONT_BYTES; i++)
        begin
            font_mem[i]  = '0;
            font_seen[i] = 1'b0;
        end
        for (i = 0; i < ROWS; i++)
            len_mem[i] = '0;
        scroll_m = 0;
        ink_m    = 16'hFFFF;
        paper_m  = 16'h0000;

        // Directed table, reset colors (ink all ones, paper zero), scroll 0.
        // Text row 0 sits in the bottom band (pixel_y 248..255) until the
        // first new line, which wraps the pointer to the last row and moves
        // row 0 to the top band.
        plan[0]  = step(FUNC_READ_PIXEL, 0, 0, 1, 16'h0000);       // empty rows after reset
        plan[1]  = step(FUNC_READ_PIXEL, 511, 255, 1, 16'h0000);
        plan[2]  = step(FUNC_LOAD_FONT, 0, 255, 1, 16'h0000);
        plan[3]  = step(FUNC_LOAD_FONT, 727, 8'h81, 1, 16'h0000); // 'z' top line
        plan[4]  = step(FUNC_LOAD_FONT, 720, 8'h01, 1, 16'h0000); // 'z' bottom line
        plan[5]  = step(FUNC_LOAD_FONT, 1023, 8'hAA, 1, 16'h0000); // past the store, dropped
        plan[6]  = step(FUNC_LOAD_FONT, FONT_BYTES, 8'h00, 1, 16'h0000);
        plan[7]  = step(FUNC_WRITE_CHAR, 0, LAST_CODE, 1, 16'h0000);
        plan[8]  = step(FUNC_WRITE_CHAR, 63, LAST_CODE, 1, 16'h0000); // lies past the length
        plan[9]  = step(FUNC_WRITE_CHAR, 1, 255, 1, 16'h0000);
        plan[10] = step(FUNC_WRITE_CHAR, 2, FIRST_CODE - 1, 0, '0);
        plan[11] = step(FUNC_WRITE_CHAR, 3, 1, 0, '0);
        plan[12] = step(FUNC_WRITE_CHAR, 4, 0, 0, '0);            // terminator, length 4
        plan[13] = step(FUNC_READ_PIXEL, 0, 248, 1, 16'hFFFF);
        plan[14] = step(FUNC_READ_PIXEL, 7, 248, 1, 16'hFFFF);
        plan[15] = step(FUNC_READ_PIXEL, 1, 248, 1, 16'h0000);
        plan[16] = step(FUNC_READ_PIXEL, 7, 255, 1, 16'hFFFF);     // flipped glyph
        plan[17] = step(FUNC_READ_PIXEL, 0, 255, 1, 16'h0000);
        plan[18] = step(FUNC_READ_PIXEL, 8, 248, 1, 16'h0000);     // code above the font
        plan[19] = step(FUNC_READ_PIXEL, 24, 248, 1, 16'h0000);    // code below the font
        plan[20] = step(FUNC_READ_PIXEL, 32, 248, 1, 16'h0000);    // past row length
        plan[21] = step(FUNC_READ_PIXEL, 504, 248, 1, 16'h0000);
        plan[22] = step(FUNC_NEW_LINE, 0, 0, 1, 16'h0000);         // pointer wraps
        plan[23] = step(FUNC_READ_PIXEL, 0, 0, 1, 16'hFFFF);
        plan[24] = step(FUNC_READ_PIXEL, 16, 7, 0, '0);

        // color settings per random phase: both extremes, then random
        inks[0] = 16'hFFFF; papers[0] = 16'h0000;
        inks[1] = 16'h0000; papers[1] = 16'hFFFF;
        inks[2] = 16'h0000; papers[2] = 16'h0000;
        inks[3] = 16'hFFFF; papers[3] = 16'hFFFF;
        inks[4] = COLOR_W'($urandom); papers[4] = COLOR_W'($urandom);
        inks[5] = COLOR_W'($urandom); papers[5] = COLOR_W'($urandom);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        for (i = 0; i < PLAN_LEN; i++)
            send(shape(plan[i].func, plan[i].a, plan[i].b), plan[i].known, plan[i].color);

        for (i = 0; i < 6; i++)
        begin
            drain();
            write_colors(inks[i], papers[i]);
            target = items_sent + 200;
            while (items_sent < target)
            begin
                calm = ($urandom_range(0, 4) == 0);
                pick = $urandom_range(0, 99);
                if (ready_glyphs.size() < 8 || pick < 20)
                    font_burst();
                else if (pick < 45)
                    line_burst();
                else if (pick < 85)
                    pixel_burst();
                else
                    emit(noise_op(func_t'($urandom_range(0, 3))));
            end
        end

        drain();
        // let any stray result item show up
        repeat (8) @(posedge clk);
        if (awaited_colors.size() != 0)
        begin
            $error("result items never delivered: %0d", awaited_colors.size());
            faults++;
        end
        if (faults == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
